// ===== rtl/core/tsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_pkg: widths and lookup tables for the table-based square root
// Holds the power-of-two root table (indexed by bit length) and the
// mantissa root table, sqrt(1 + m/32) in Q15.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int unsigned ValueW   = 31;
  localparam int unsigned MantW    = 6;
  localparam int unsigned MantIdxW = MantW - 1;
  localparam int unsigned LenW     = $clog2(ValueW + 1);
  localparam int unsigned RootW    = 16;
  localparam int unsigned ProdW    = 2 * RootW;
  localparam int unsigned FracShift = 15;

  localparam logic [LenW-1:0] MantLen = LenW'(MantW);

  // Integer root of 2^(n-1) for bit length n; entry 0 gives zero for a zero input
  localparam logic [RootW-1:0] POW_ROOT [2**LenW] = '{
    16'd0,     16'd1,     16'd1,     16'd2,     16'd2,     16'd4,     16'd5,
    16'd8,     16'd11,    16'd16,    16'd22,    16'd32,    16'd45,    16'd64,
    16'd90,    16'd128,   16'd181,   16'd256,   16'd362,   16'd512,   16'd724,
    16'd1024,  16'd1448,  16'd2048,  16'd2896,  16'd4096,  16'd5792,  16'd8192,
    16'd11585, 16'd16384, 16'd23170, 16'd32768
  };

  // sqrt(1 + m/32) in Q15
  localparam logic [RootW-1:0] MANT_ROOT [2**MantIdxW] = '{
    16'd32768, 16'd33276, 16'd33776, 16'd34269, 16'd34755, 16'd35235,
    16'd35708, 16'd36174, 16'd36635, 16'd37090, 16'd37540, 16'd37984,
    16'd38423, 16'd38858, 16'd39287, 16'd39712, 16'd40132, 16'd40548,
    16'd40960, 16'd41367, 16'd41771, 16'd42170, 16'd42566, 16'd42959,
    16'd43347, 16'd43733, 16'd44115, 16'd44493, 16'd44869, 16'd45241,
    16'd45611, 16'd45977
  };

  localparam logic [RootW-1:0] RootMax = 16'd45977;

endpackage : tsr_pkg
`default_nettype wire

// ===== rtl/core/table_integer_square_root.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// table_integer_square_root: pipelined table-based square root approximation
// Returns an approximate root of a 31-bit unsigned value from a bit-length
// table and a mantissa table combined by one 16x16 multiply.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is accepted at a rising edge where start is high and busy
//   is low. busy is always low: the pipeline takes a new value every cycle.
//   Each result appears on root_approx_o for exactly one cycle with done_o
//   high, once the transaction has passed through every stage listed below,
//   in acceptance order.
//   Throughput: one transaction per cycle, set by the four-stage pipeline
//     stage 1: input register
//     stage 2: bit length (priority encoder)
//     stage 3: mantissa shift and both table lookups
//     stage 4: 16x16 multiply; result is the product shifted right by 15
//   The receiver cannot stall, so no transaction is ever held back.
//   Reset clears all valid bits; data registers are not reset. Results are
//   strobed out only for accepted transactions.
// ----------------------------------------------------------------------------
module table_integer_square_root
  import tsr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   done_o,
  output logic [RootW-1:0]       root_approx_o
);

  logic                accept;
  logic                s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic [ValueW-1:0]   s1_val_q, s2_val_q;
  logic [LenW-1:0]     len_d, s2_len_q;
  logic [MantW-1:0]    mant_d;
  logic [LenW-1:0]     shl_amt, shr_amt;
  logic [ValueW-1:0]   shl_val, shr_val;
  logic [RootW-1:0]    pow_q, frac_q;
  logic [ProdW-1:0]    prod_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // Stage 1: input register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_val_q <= value_i;
    end
  end

  // Stage 2: bit length of the value
  always_comb begin
    len_d = '0;
    for (int i = 0; i < ValueW; i++) begin
      if (s1_val_q[i]) begin
        len_d = LenW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s2_val_q <= s1_val_q;
    s2_len_q <= len_d;
  end

  // Stage 3: normalize to a 6-bit mantissa, then look up both tables
  assign shl_amt = MantLen - s2_len_q;
  assign shr_amt = s2_len_q - MantLen;
  assign shl_val = s2_val_q << shl_amt;
  assign shr_val = s2_val_q >> shr_amt;
  assign mant_d  = (s2_len_q <= MantLen) ? shl_val[MantW-1:0] : shr_val[MantW-1:0];

  always_ff @(posedge clk_i) begin
    pow_q  <= POW_ROOT[s2_len_q];
    frac_q <= MANT_ROOT[mant_d[MantIdxW-1:0]];
  end

  // Stage 4: multiply; Q15 scaling removed at the output
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(pow_q) * ProdW'(frac_q);
  end

  assign done_o        = s4_vld_q;
  assign root_approx_o = prod_q[FracShift +: RootW];

  // Assertions
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("accepted transaction not delivered after four cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result strobed without a matching transaction");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && value_i == '0) |-> ##4 (root_approx_o == '0))
    else $error("zero input gave a nonzero root");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (root_approx_o <= RootMax))
    else $error("root above table maximum");

endmodule : table_integer_square_root
`default_nettype wire
